### design/bbr_pkg.sv
// Package for the 3x3 RGB box blur: shared constants, op flags, reciprocal table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bbr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 13;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // sum of up to nine 8-bit values plus rounding
  localparam int ROWSUM_W    = 10;
  localparam int TOTAL_W     = 12;
  localparam int NCNT_W      = 4;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  typedef struct packed {
    logic emit;
    logic skip_top;
    logic skip_bot;
    logic skip_left;
    logic skip_right;
    logic eol;
    logic eof;
  } op_flags_t;

  // ceil(2^16 / n); exact quotient for sums below 2^12
  function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

### design/box_blur_3x3_rgb.sv
// 3x3 RGB box blur, top level. A result is registered through the queue and back end after
// the request completing its neighborhood (one row plus one pixel later in raster order) is
// accepted. Throughput: one request per cycle while the queue has room; a one-row frame's
// first drain tick needs a second push. Reset clears counters, window and pipeline and loads
// 640x480; line stores are not cleared. Depends on bbr_pkg, bbr_front, bbr_queue, bbr_back.
`timescale 1ns / 1ps

module box_blur_3x3_rgb import bbr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                  s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [PIX_W-1:0]      m_axis_tdata,   // red_out, green_out, blue_out
  output logic                  m_axis_tlast,   // end_of_line
  output logic                  m_axis_tuser    // end_of_frame
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             q_rdy, op_push, head_vld, pop;
  logic [PIX_W-1:0] op_px, head_px;
  logic [COL_W-1:0] op_col, head_col;
  op_flags_t        op_flags, head_flags;

  bbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .req_vld_i   (s_axis_tvalid),
    .req_rdy_o   (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_kind_i  (s_axis_tuser),
    .queue_rdy_i (q_rdy),
    .op_push_o   (op_push),
    .op_px_o     (op_px),
    .op_col_o    (op_col),
    .op_flags_o  (op_flags)
  );

  bbr_queue #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (op_push),
    .px_i      (op_px),
    .col_i     (op_col),
    .flags_i   (op_flags),
    .in_rdy_o  (q_rdy),
    .pop_i     (pop),
    .out_vld_o (head_vld),
    .px_o      (head_px),
    .col_o     (head_col),
    .flags_o   (head_flags)
  );

  bbr_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_vld_i   (head_vld),
    .head_px_i    (head_px),
    .head_col_i   (head_col),
    .head_flags_i (head_flags),
    .pop_o        (pop),
    .res_vld_o    (m_axis_tvalid),
    .res_rdy_i    (m_axis_tready),
    .res_data_o   (m_axis_tdata),
    .res_eol_o    (m_axis_tlast),
    .res_eof_o    (m_axis_tuser)
  );

endmodule

### design/bbr_front.sv
// Front end of the box blur: geometry registers, input/output position counters,
// classification of pixels and drain ticks into window ops. Uses bbr_pkg.
`timescale 1ns / 1ps

module bbr_front import bbr_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      req_vld_i,
  output logic                      req_rdy_o,
  input  logic [PIX_W-1:0]          req_data_i,   // red, green, blue from bit 0 up
  input  logic                      req_kind_i,
  input  logic                      queue_rdy_i,
  output logic                      op_push_o,
  output logic [PIX_W-1:0]          op_px_o,      // {red, green, blue}
  output logic [$clog2(MAX_WIDTH)-1:0] op_col_o,
  output op_flags_t                 op_flags_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int GW    = $clog2(MAX_WIDTH + 1);
  localparam int GH    = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  logic [FRAME_WIDTH_W-1:0]  cfg_width_q;
  logic [FRAME_HEIGHT_W-1:0] cfg_height_q;
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             frame_done_q, frame_done_d;
  logic             pend_q, pend_d;

  logic [GW-1:0]    w_val;
  logic [GH-1:0]    h_val;
  logic [ROW_W-1:0] h_row, in_row_inc;
  logic             accept, do_push, primed;
  logic             col_last, out_col_last, out_row_last;

  always_comb begin
    if (cfg_width_q == '0) begin
      w_val = GW'(1);
    end else if (cfg_width_q > MAX_WIDTH) begin
      w_val = GW'(MAX_WIDTH);
    end else begin
      w_val = GW'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_val = GH'(1);
    end else if (cfg_height_q > MAX_HEIGHT) begin
      h_val = GH'(MAX_HEIGHT);
    end else begin
      h_val = GH'(cfg_height_q);
    end
  end

  assign h_row        = ROW_W'(h_val);
  assign in_row_inc   = in_row_q + ROW_W'(1);
  assign col_last     = (GW'(in_col_q) + GW'(1)) == w_val;
  assign out_col_last = (GW'(out_col_q) + GW'(1)) >= w_val;
  assign out_row_last = (out_row_q + ROW_W'(1)) >= h_row;
  assign primed       = (in_row_q >= ROW_W'(2)) ||
                        ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

  assign req_rdy_o = queue_rdy_i && !pend_q;
  assign accept    = req_vld_i && req_rdy_o;
  assign do_push   = (accept && (req_kind_i == REQ_PIXEL) && !frame_done_q) ||
                     (accept && (req_kind_i == REQ_DRAIN) && frame_done_q) ||
                     (pend_q && queue_rdy_i);

  assign op_push_o = do_push;
  assign op_col_o  = in_col_q;
  assign op_px_o   = (accept && (req_kind_i == REQ_PIXEL)) ?
                     {req_data_i[7:0], req_data_i[15:8], req_data_i[23:16]} : '0;

  always_comb begin
    op_flags_o            = '0;
    op_flags_o.emit       = primed;
    op_flags_o.skip_top   = (out_row_q == '0);
    op_flags_o.skip_bot   = out_row_last;
    op_flags_o.skip_left  = (out_col_q == '0);
    op_flags_o.skip_right = out_col_last;
    op_flags_o.eol        = out_col_last;
    op_flags_o.eof        = out_col_last && out_row_last;
  end

  always_comb begin
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    frame_done_d = frame_done_q;
    pend_d       = pend_q;
    if (do_push) begin
      if (col_last) begin
        in_col_d = '0;
        in_row_d = in_row_inc;
        if (in_row_inc == h_row) begin
          frame_done_d = 1'b1;
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
      if (primed) begin
        if (out_col_last && out_row_last) begin
          in_col_d     = '0;
          in_row_d     = '0;
          out_col_d    = '0;
          out_row_d    = '0;
          frame_done_d = 1'b0;
        end else if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
    // one-row frame: first drain tick needs a second push
    if (accept && (req_kind_i == REQ_DRAIN) && frame_done_q && !primed) begin
      pend_d = 1'b1;
    end else if (pend_q && queue_rdy_i) begin
      pend_d = 1'b0;
    end
    if (cfg_we_i) begin
      in_col_d     = '0;
      in_row_d     = '0;
      out_col_d    = '0;
      out_row_d    = '0;
      frame_done_d = 1'b0;
      pend_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= FRAME_WIDTH_RST;
      cfg_height_q <= FRAME_HEIGHT_RST;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      frame_done_q <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_addr_i == REG_FRAME_WIDTH)) begin
        cfg_width_q <= cfg_data_i[FRAME_WIDTH_W-1:0];
      end
      if (cfg_we_i && (cfg_addr_i == REG_FRAME_HEIGHT)) begin
        cfg_height_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
      end
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      frame_done_q <= frame_done_d;
      pend_q       <= pend_d;
    end
  end

endmodule

### design/bbr_queue.sv
// Short op queue between the box blur front end and the window/filter back end.
// Uses bbr_pkg for the op flag type and queue depth.
`timescale 1ns / 1ps

module bbr_queue import bbr_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [PIX_W-1:0]             px_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  op_flags_t                    flags_i,
  output logic                         in_rdy_o,
  input  logic                         pop_i,
  output logic                         out_vld_o,
  output logic [PIX_W-1:0]             px_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output op_flags_t                    flags_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PIX_W-1:0] px_mem   [QUEUE_DEPTH];
  logic [COL_W-1:0] col_mem  [QUEUE_DEPTH];
  op_flags_t        flag_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_rdy_o  = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign out_vld_o = cnt_q != '0;
  assign px_o      = px_mem[rd_ptr_q];
  assign col_o     = col_mem[rd_ptr_q];
  assign flags_o   = flag_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      px_mem[wr_ptr_q]   <= px_i;
      col_mem[wr_ptr_q]  <= col_i;
      flag_mem[wr_ptr_q] <= flags_i;
    end
  end

endmodule

### design/bbr_back.sv
// Back end of the box blur: line store memory, 3x3 window, masked sums,
// reciprocal divide and output register. Uses bbr_pkg.
`timescale 1ns / 1ps

module bbr_back import bbr_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_vld_i,
  input  logic [PIX_W-1:0]             head_px_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] head_col_i,
  input  op_flags_t                    head_flags_i,
  output logic                         pop_o,
  output logic                         res_vld_o,
  input  logic                         res_rdy_i,
  output logic [PIX_W-1:0]             res_data_o,  // red, green, blue from bit 0 up
  output logic                         res_eol_o,
  output logic                         res_eof_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LINE_W = 2 * PIX_W;
  localparam int PROD_W = TOTAL_W + RECIP_W;

  // each entry: {row two above, row above}
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q, fwd_q, line_cur, line_wr;
  logic              fwd_hit_q;

  logic              adv, pop, mem_we;
  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic [PIX_W-1:0]  s1_px_q;
  logic [COL_W-1:0]  s1_col_q;
  op_flags_t         s1_flags_q, s2_flags_q, s3_flags_q, s4_flags_q;

  logic [PIX_W-1:0]  window_q [9];

  logic [2:0][2:0][ROWSUM_W-1:0] rs_d, rs_q;
  logic [1:0]                    n_rows, n_cols;
  logic [NCNT_W-1:0]             cnt_d, cnt_q;
  logic [2:0][TOTAL_W-1:0]       tot_d, tot_q;
  logic [RECIP_W-1:0]            rcp_q;
  logic [2:0][PROD_W-1:0]        prod;
  logic [2:0][CH_W-1:0]          quo, res_q;
  logic                          eol_q, eof_q;

  assign adv    = !out_vld_q || res_rdy_i;
  assign pop    = head_vld_i && adv;
  assign pop_o  = pop;
  assign mem_we = adv && s1_vld_q;

  assign line_cur = fwd_hit_q ? fwd_q : rd_q;
  assign line_wr  = {line_cur[PIX_W-1:0], s1_px_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_col_q] <= line_wr;
    end
    if (pop) begin
      rd_q     <= line_mem[head_col_i];
      fwd_q    <= line_wr;
      s1_px_q  <= head_px_i;
      s1_col_q <= head_col_i;
    end
  end

  // masked row sums per channel
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int ch = 0; ch < 3; ch++) begin
        rs_d[r][ch] = '0;
        for (int k = 0; k < 3; k++) begin
          if (!((k == 0) && s2_flags_q.skip_left) && !((k == 2) && s2_flags_q.skip_right)) begin
            rs_d[r][ch] = rs_d[r][ch] +
                          ROWSUM_W'(window_q[r*3+k][PIX_W-1-CH_W*ch -: CH_W]);
          end
        end
        if (((r == 0) && s2_flags_q.skip_top) || ((r == 2) && s2_flags_q.skip_bot)) begin
          rs_d[r][ch] = '0;
        end
      end
    end
  end

  assign n_rows = 2'd3 - 2'(s2_flags_q.skip_top) - 2'(s2_flags_q.skip_bot);
  assign n_cols = 2'd3 - 2'(s2_flags_q.skip_left) - 2'(s2_flags_q.skip_right);
  assign cnt_d  = NCNT_W'(n_rows) * NCNT_W'(n_cols);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot_d[ch] = TOTAL_W'(rs_q[0][ch]) + TOTAL_W'(rs_q[1][ch]) + TOTAL_W'(rs_q[2][ch]) +
                  TOTAL_W'(cnt_q >> 1);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_W'(tot_q[ch]) * PROD_W'(rcp_q);
      quo[ch]  = prod[ch][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_flags_q <= s1_flags_q;
      rs_q       <= rs_d;
      cnt_q      <= cnt_d;
      s3_flags_q <= s2_flags_q;
      tot_q      <= tot_d;
      rcp_q      <= recip(cnt_q);
      s4_flags_q <= s3_flags_q;
      res_q      <= quo;
      eol_q      <= s4_flags_q.eol;
      eof_q      <= s4_flags_q.eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_flags_q <= '0;
      fwd_hit_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window_q[i] <= '0;
      end
    end else if (adv) begin
      s1_vld_q  <= pop;
      fwd_hit_q <= pop && s1_vld_q && (head_col_i == s1_col_q);
      if (pop) begin
        s1_flags_q <= head_flags_i;
      end
      if (s1_vld_q) begin
        for (int r = 0; r < 3; r++) begin
          window_q[r*3]   <= window_q[r*3+1];
          window_q[r*3+1] <= window_q[r*3+2];
        end
        window_q[2] <= line_cur[LINE_W-1:PIX_W];
        window_q[5] <= line_cur[PIX_W-1:0];
        window_q[8] <= s1_px_q;
      end
      s2_vld_q  <= s1_vld_q && s1_flags_q.emit;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  assign res_vld_o  = out_vld_q;
  assign res_data_o = {res_q[2], res_q[1], res_q[0]};
  assign res_eol_o  = eol_q;
  assign res_eof_o  = eof_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for box_blur_3x3_rgb: random streams of RGB frames and drain
// requests, checked against an in-bench model of the 3x3 blur. Depends on bbr_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import bbr_pkg::*;

  localparam int MAX_W  = DEF_MAX_WIDTH;
  localparam int MAX_H  = DEF_MAX_HEIGHT;
  localparam int SETTLE = 20;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } blur_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eol;
    logic       eof;
  } blur_px_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata = '0;    // red_in, green_in, blue_in
  logic                  s_axis_tuser = REQ_PIXEL; // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;         // red_out, green_out, blue_out
  logic                  m_axis_tlast;         // end_of_line
  logic                  m_axis_tuser;         // end_of_frame

  box_blur_3x3_rgb u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  blur_req_t pixel_feed[$];
  blur_px_t  blurred_due[$];

  int mismatches    = 0;
  int pixels_sent   = 0;
  int drains_sent   = 0;
  int blurred_seen  = 0;
  int geometries    = 0;
  int stim_count    = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int src_gap       = 0;
  int sink_gap      = 0;

  // blur model state
  logic [FRAME_WIDTH_W-1:0]  width_reg  = FRAME_WIDTH_RST;
  logic [FRAME_HEIGHT_W-1:0] height_reg = FRAME_HEIGHT_RST;
  logic [PIX_W-1:0] row_above [MAX_W] = '{default: '0};
  logic [PIX_W-1:0] row_prev  [MAX_W] = '{default: '0};
  logic [PIX_W-1:0] win [9] = '{default: '0};
  int unsigned col_in = 0, row_in = 0, col_out = 0, row_out = 0;
  bit frame_full = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  function automatic void frame_restart();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    frame_full = 1'b0;
  endfunction

  function automatic bit shift_in(logic [PIX_W-1:0] px);
    int unsigned w, c;
    logic [PIX_W-1:0] top, mid;
    bit primed;
    w = clamp_dim(width_reg, MAX_W);
    c = (col_in < MAX_W) ? col_in : MAX_W - 1;
    top = row_above[c];
    mid = row_prev[c];
    primed = (row_in * w + col_in) >= w + 1;
    row_above[c] = mid;
    row_prev[c] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
      if (row_in == clamp_dim(height_reg, MAX_H)) frame_full = 1'b1;
    end
    return primed;
  endfunction

  function automatic void emit_blurred();
    int unsigned w, h, n;
    int unsigned acc_r, acc_g, acc_b;
    blur_px_t px;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    n = 0;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (r == 0 && row_out == 0) continue;
        if (r == 2 && row_out + 1 >= h) continue;
        if (k == 0 && col_out == 0) continue;
        if (k == 2 && col_out + 1 >= w) continue;
        acc_r += win[r*3+k][23:16];
        acc_g += win[r*3+k][15:8];
        acc_b += win[r*3+k][7:0];
        n++;
      end
    end
    px.red   = 8'((acc_r + n / 2) / n);
    px.green = 8'((acc_g + n / 2) / n);
    px.blue  = 8'((acc_b + n / 2) / n);
    px.eol   = (col_out + 1 >= w);
    px.eof   = px.eol && (row_out + 1 >= h);
    blurred_due.push_back(px);
    if (px.eof) begin
      frame_restart();
    end else if (px.eol) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
  endfunction

  function automatic void blur_predict(blur_req_t rq);
    bit primed;
    if (rq.kind == REQ_PIXEL) begin
      if (frame_full) return;
      primed = shift_in({rq.red, rq.green, rq.blue});
    end else begin
      if (!frame_full) return;
      primed = shift_in('0);
      if (!primed) primed = shift_in('0);
    end
    if (primed) emit_blurred();
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // source side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (pixel_feed[0].kind == REQ_DRAIN) drains_sent++;
        else pixels_sent++;
        blur_predict(pixel_feed.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_feed.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 14);
          s_axis_tvalid <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pixel_feed[0].blue, pixel_feed[0].green, pixel_feed[0].red};
          s_axis_tuser  <= pixel_feed[0].kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  blur_px_t want_px;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        blurred_seen++;
        if (blurred_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got data %0h eol %0b eof %0b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatches++;
        end else begin
          want_px = blurred_due.pop_front();
          check_field("red", want_px.red, m_axis_tdata[7:0]);
          check_field("green", want_px.green, m_axis_tdata[15:8]);
          check_field("blue", want_px.blue, m_axis_tdata[23:16]);
          check_field("end_of_line", {7'd0, want_px.eol}, {7'd0, m_axis_tlast});
          check_field("end_of_frame", {7'd0, want_px.eof}, {7'd0, m_axis_tuser});
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic blur_req_t make_req(logic kind, logic [PIX_W-1:0] rgb);
    blur_req_t rq;
    rq.kind = kind;
    {rq.red, rq.green, rq.blue} = rgb;
    return rq;
  endfunction

  function automatic blur_req_t rand_req(logic kind);
    logic [PIX_W-1:0] rgb;
    case ($urandom_range(0, 7))
      0: rgb = '0;
      1: rgb = '1;
      2: rgb = {{8{1'($urandom())}}, {8{1'($urandom())}}, {8{1'($urandom())}}};
      default: rgb = 24'($urandom());
    endcase
    return make_req(kind, rgb);
  endfunction

  // stop_at below w*h cuts the frame short
  task automatic queue_frame(int unsigned w, int unsigned h, int unsigned stop_at);
    int unsigned total;
    total = w * h;
    for (int unsigned p = 0; p < total && p < stop_at; p++) begin
      if ($urandom_range(0, 39) == 0) pixel_feed.push_back(rand_req(REQ_DRAIN));
      pixel_feed.push_back(rand_req(REQ_PIXEL));
      stim_count++;
    end
    if (stop_at < total) return;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) pixel_feed.push_back(rand_req(REQ_PIXEL));
    end
    repeat ((h == 1) ? w : w + 1) begin
      pixel_feed.push_back(rand_req(REQ_DRAIN));
      stim_count++;
    end
    if ($urandom_range(0, 3) == 0) pixel_feed.push_back(rand_req(REQ_DRAIN));
  endtask

  task automatic wait_idle();
    while (pixel_feed.size() != 0 || s_axis_tvalid || blurred_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    if (idx == REG_FRAME_WIDTH) width_reg = val[FRAME_WIDTH_W-1:0];
    else height_reg = val;
    frame_restart();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // upper width bits beyond the register are don't-care
  task automatic configure(int unsigned w_raw, int unsigned h_raw);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, {2'($urandom_range(0, 3)), 11'(w_raw)});
    write_reg(REG_FRAME_HEIGHT, 13'(h_raw));
    geometries++;
  endtask

  logic [PIX_W-1:0] checker_px [9] = '{24'hFF0080, 24'h00FF7F, 24'h01FEFF, 24'hFFFFFF,
                                       24'h000000, 24'h807F01, 24'hFE0100, 24'h7F80FE,
                                       24'hFF00FF};
  int unsigned w_raw, h_raw, w_eff, h_eff;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default geometry: early drain is ignored, a lone pixel is dropped by the restart
    pixel_feed.push_back(rand_req(REQ_DRAIN));
    pixel_feed.push_back(rand_req(REQ_PIXEL));

    configure(3, 3);
    foreach (checker_px[i]) pixel_feed.push_back(make_req(REQ_PIXEL, checker_px[i]));
    pixel_feed.push_back(make_req(REQ_PIXEL, 24'h123456));
    repeat (5) pixel_feed.push_back(make_req(REQ_DRAIN, 24'hFFFFFF));

    configure(0, 0);
    pixel_feed.push_back(make_req(REQ_PIXEL, 24'hFF00FF));
    pixel_feed.push_back(make_req(REQ_DRAIN, 24'h000000));

    configure(2, 1);
    queue_frame(2, 1, 2);

    // tall and wide geometries, partial frames only
    src_idle_pct  = 5;
    sink_idle_pct = 5;
    configure(3, 8191);
    queue_frame(3, MAX_H, 40);
    configure(5, MAX_H);
    queue_frame(5, MAX_H, 40);
    configure(2047, 2);
    queue_frame(MAX_W, 2, 40);

    stim_count = 0;
    while (stim_count < 600) begin
      if (stim_count > 480) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
        sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      end
      case ($urandom_range(0, 4))
        0: begin
          w_raw = $urandom_range(0, 1);
          h_raw = $urandom_range(1, 6);
        end
        1: begin
          w_raw = $urandom_range(2, 16);
          h_raw = $urandom_range(0, 1);
        end
        default: begin
          w_raw = $urandom_range(2, 16);
          h_raw = $urandom_range(2, 9);
        end
      endcase
      w_eff = clamp_dim(w_raw, MAX_W);
      h_eff = clamp_dim(h_raw, MAX_H);
      configure(w_raw, h_raw);
      repeat ($urandom_range(1, 3)) queue_frame(w_eff, h_eff, w_eff * h_eff);
      if ($urandom_range(0, 3) == 0)
        queue_frame(w_eff, h_eff, $urandom_range(1, w_eff * h_eff));
    end

    wait_idle();
    $display("Covered %0d geometries: %0d pixel and %0d drain requests, %0d blurred pixels",
             geometries, pixels_sent, drains_sent, blurred_seen);
    if (mismatches == 0 && blurred_due.size() == 0)
      $display("box_blur_3x3_rgb verification clean");
    else
      $display("box_blur_3x3_rgb verification failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", blurred_due.size());
    $display("box_blur_3x3_rgb verification failed");
    $finish;
  end

endmodule
